FILE: rtl/sm3_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and round functions of the SM3 hash engine.
// Used by the top level and the round unit of the engine; depends on nothing.
package sm3_pkg;

    localparam logic [31:0] IV0 = 32'h7380166f;
    localparam logic [31:0] IV1 = 32'h4914b2b9;
    localparam logic [31:0] IV2 = 32'h172442d7;
    localparam logic [31:0] IV3 = 32'hda8a0600;
    localparam logic [31:0] IV4 = 32'ha96f30bc;
    localparam logic [31:0] IV5 = 32'h163138aa;
    localparam logic [31:0] IV6 = 32'he38dee4d;
    localparam logic [31:0] IV7 = 32'hb0fb0e4e;
    localparam logic [31:0] TCONST_LO = 32'h79cc4519;
    localparam logic [31:0] TCONST_HI = 32'h7a879d8a;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    typedef logic [31:0] t_word;
    typedef t_word [7:0] t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_rnd_ctl;

    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic t_word perm0(input t_word x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic t_word perm1(input t_word x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

    function automatic t_state init_vec();
        t_state v;
        v[0] = IV0; v[1] = IV1; v[2] = IV2; v[3] = IV3;
        v[4] = IV4; v[5] = IV5; v[6] = IV6; v[7] = IV7;
        return v;
    endfunction

endpackage

FILE: rtl/sm3_hash_engine_unit.sv
`timescale 1ns / 1ps
// Top level of the SM3 hash engine: word intake, padding sequencer and
// digest output. Depends on sm3_pkg and sm3_round.
//
// Usage: message words enter on the input channel (i_valid, o_stall), big
// endian, four bytes each; the final word carries i_last and i_valid_bytes.
// Each accepted word is stored in the block buffer. The sixteenth word of a
// block sets the start register (r_start) of the shared round unit; it runs
// 64 rounds at one round per cycle, after which the new chaining value is
// taken. The input stalls while a block is hashed. On the final word the
// sequencer appends the pad byte, zero words and the 64-bit bit length, one
// word per cycle except while a full block is hashed in between. The first
// digest word appears once the last block is hashed and its chaining value
// is taken, whether the padding fits in the current block or needs an extra
// block. The eight digest words then leave on the output channel
// (o_valid, i_stall), one per cycle, index 0 first, with o_last_word on
// index 7. While the receiver stalls, the current digest word holds and no
// new request is taken. After the eighth word the chaining value returns to
// the initial vector. Synchronous reset loads the initial vector and
// clears all control state; no request is taken during reset.
module sm3_hash_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sm3_pkg::*;

    typedef enum logic [4:0] {
        S_COLLECT = 5'b00001,
        S_PAD     = 5'b00010,
        S_HASH    = 5'b00100,
        S_WAIT    = 5'b01000,
        S_OUT     = 5'b10000
    } t_state_e;

    t_state_e     r_st, n_st;
    t_word [15:0] r_blk;
    logic [3:0]   r_cnt;
    logic [63:0]  r_len;
    logic         r_fin;
    logic         r_in_pad;
    logic         r_len_hi_done;
    logic         r_fin_pad_done;
    t_state       r_cv;
    logic [2:0]   r_idx;
    logic         r_start;

    t_rnd_ctl     rnd_ctl;
    t_state       rnd_cv;

    logic         acc_in;
    logic [2:0]   nb;
    t_word        pad_word;
    t_word        mask;
    logic [63:0]  len_add;
    t_word        push_val;
    logic         push;

    sm3_round u_round (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_start),
        .i_block(r_blk),
        .i_cv   (r_cv),
        .o_ctl  (rnd_ctl),
        .o_cv   (rnd_cv)
    );

    assign acc_in = i_valid && !o_stall;
    assign o_stall = (r_st != S_COLLECT);

    always_comb begin
        nb = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
        if (!i_last) begin
            nb = 3'd4;
        end
        case (nb)
            3'd0: mask = 32'h0;
            3'd1: mask = 32'hff000000;
            3'd2: mask = 32'hffff0000;
            3'd3: mask = 32'hffffff00;
            default: mask = 32'hffffffff;
        endcase
        case (nb)
            3'd0: pad_word = {PAD_MARK, 24'h0};
            3'd1: pad_word = (i_data_word & mask) | {8'h0, PAD_MARK, 16'h0};
            3'd2: pad_word = (i_data_word & mask) | {16'h0, PAD_MARK, 8'h0};
            3'd3: pad_word = (i_data_word & mask) | {24'h0, PAD_MARK};
            default: pad_word = i_data_word;
        endcase
        len_add = r_len + {58'h0, nb, 3'b000};
    end

    // Input words or padding: the pad mark word (if the final word was
    // full), zero fill up to word 14, then the length high and low words.
    always_comb begin
        push = 1'b0;
        push_val = '0;
        if (r_st == S_COLLECT && acc_in) begin
            push = 1'b1;
            push_val = i_last ? pad_word : i_data_word;
        end else if (r_st == S_PAD) begin
            push = 1'b1;
            if (r_in_pad) begin
                push_val = {PAD_MARK, 24'h0};
            end else if (r_cnt == 4'd14) begin
                push_val = r_len[63:32];
            end else if (r_cnt == 4'd15 && r_len_hi_done) begin
                push_val = r_len[31:0];
            end else begin
                push_val = '0;
            end
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_COLLECT: begin
                if (acc_in) begin
                    if (r_cnt == 4'd15) begin
                        n_st = S_HASH;
                    end else if (i_last) begin
                        n_st = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_cnt == 4'd15) begin
                    n_st = S_HASH;
                end
            end
            S_HASH: n_st = S_WAIT;
            S_WAIT: begin
                if (rnd_ctl.done) begin
                    if (!r_fin) begin
                        n_st = S_COLLECT;
                    end else if (r_fin_pad_done) begin
                        n_st = S_OUT;
                    end else begin
                        n_st = S_PAD;
                    end
                end
            end
            S_OUT: begin
                if (!i_stall && r_idx == 3'd7) begin
                    n_st = S_COLLECT;
                end
            end
            default: n_st = S_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_blk[r_cnt] <= push_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st           <= S_COLLECT;
            r_cnt          <= '0;
            r_len          <= '0;
            r_fin          <= 1'b0;
            r_in_pad       <= 1'b0;
            r_len_hi_done  <= 1'b0;
            r_fin_pad_done <= 1'b0;
            r_cv           <= init_vec();
            r_idx          <= '0;
            r_start        <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_start <= (n_st == S_HASH) && (r_st != S_HASH);
            if (push) begin
                r_cnt <= r_cnt + 4'd1;
            end
            if (r_st == S_COLLECT && acc_in) begin
                r_len <= len_add;
                if (i_last) begin
                    r_fin    <= 1'b1;
                    r_in_pad <= (nb == 3'd4);
                end
            end
            if (r_st == S_PAD) begin
                r_in_pad <= 1'b0;
                if (r_cnt == 4'd14 && !r_in_pad) begin
                    r_len_hi_done <= 1'b1;
                end
                if (r_cnt == 4'd15 && r_len_hi_done && !r_in_pad) begin
                    r_fin_pad_done <= 1'b1;
                end
            end
            if (rnd_ctl.done) begin
                r_cv <= rnd_cv;
            end
            if (r_st == S_OUT && !i_stall) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    r_cv           <= init_vec();
                    r_len          <= '0;
                    r_fin          <= 1'b0;
                    r_len_hi_done  <= 1'b0;
                    r_fin_pad_done <= 1'b0;
                    r_cnt          <= '0;
                end
            end
        end
    end

    assign o_valid       = (r_st == S_OUT);
    assign o_digest_word = r_cv[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd7);

endmodule

FILE: rtl/sm3_round.sv
`timescale 1ns / 1ps
// Shared SM3 round unit: one compression round per cycle with on-the-fly
// message expansion over a sixteen-word window. Depends on sm3_pkg.
module sm3_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  sm3_pkg::t_word [15:0] i_block,
    input  sm3_pkg::t_state      i_cv,
    output sm3_pkg::t_rnd_ctl    o_ctl,
    output sm3_pkg::t_state      o_cv
);
    import sm3_pkg::*;

    t_word [15:0] r_w;
    t_state       r_v;
    t_state       r_cv_in;
    logic [5:0]   r_round;
    logic         r_busy;
    logic         r_done;

    t_word  w_new;
    t_word  wj;
    t_word  wpj;
    t_word  tj;
    t_word  a12;
    t_word  ss1;
    t_word  ss2;
    t_word  ff;
    t_word  gg;
    t_word  tt1;
    t_word  tt2;

    always_comb begin
        w_new = perm1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 5'd15))
              ^ rotl(r_w[3], 5'd7) ^ r_w[10];
        wj  = r_w[0];
        wpj = r_w[0] ^ r_w[4];
        tj  = (r_round < 6'd16) ? TCONST_LO : TCONST_HI;
        a12 = rotl(r_v[0], 5'd12);
        ss1 = rotl(a12 + r_v[4] + rotl(tj, r_round[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (r_round < 6'd16) begin
            ff = r_v[0] ^ r_v[1] ^ r_v[2];
            gg = r_v[4] ^ r_v[5] ^ r_v[6];
        end else begin
            ff = (r_v[0] & r_v[1]) | (r_v[0] & r_v[2]) | (r_v[1] & r_v[2]);
            gg = (r_v[4] & r_v[5]) | (~r_v[4] & r_v[6]);
        end
        tt1 = ff + r_v[3] + ss2 + wpj;
        tt2 = gg + r_v[7] + ss1 + wj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_w     <= i_block;
            r_v     <= i_cv;
            r_cv_in <= i_cv;
        end else if (r_busy) begin
            r_w  <= {w_new, r_w[15:1]};
            r_v[3] <= r_v[2];
            r_v[2] <= rotl(r_v[1], 5'd9);
            r_v[1] <= r_v[0];
            r_v[0] <= tt1;
            r_v[7] <= r_v[6];
            r_v[6] <= rotl(r_v[5], 5'd19);
            r_v[5] <= r_v[4];
            r_v[4] <= perm0(tt2);
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
    assign o_cv        = r_cv_in ^ r_v;

endmodule

FILE: rtl/sm3_hash_engine_unit_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the SM3 hash engine and its bind statement.
// Depends only on the ports of sm3_hash_engine_unit.
module sm3_hash_engine_unit_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("request taken during digest output");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last word flag mismatch");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_word) |=>
        (o_valid && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest index did not advance");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_digest_word)))
        else $error("stalled digest word changed");

endmodule

bind sm3_hash_engine_unit sm3_hash_engine_unit_chk u_chk (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench of the SM3 hash engine: drives random and directed messages,
// predicts the digests in place and compares every digest word.
// Depends on sm3_pkg and sm3_hash_engine_unit.

class digest_board;
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    int          nwords;
    logic [63:0] bitlen;
    logic [31:0] exp_word [$];
    logic [2:0]  exp_index [$];
    logic        exp_last [$];
    int          errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        chain[0] = sm3_pkg::IV0; chain[1] = sm3_pkg::IV1;
        chain[2] = sm3_pkg::IV2; chain[3] = sm3_pkg::IV3;
        chain[4] = sm3_pkg::IV4; chain[5] = sm3_pkg::IV5;
        chain[6] = sm3_pkg::IV6; chain[7] = sm3_pkg::IV7;
        nwords = 0;
        bitlen = '0;
    endfunction

    function logic [31:0] rl(logic [31:0] x, int n);
        n = n % 32;
        if (n == 0) return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
        logic [31:0] w [68];
        logic [31:0] r [8];
        logic [31:0] tj, a12, ss1, ss2, f, g, t1, t2, p;
        for (int j = 0; j < 16; j++) w[j] = blk[j];
        for (int j = 16; j < 68; j++) begin
            p = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
            w[j] = p ^ rl(p, 15) ^ rl(p, 23) ^ rl(w[j-13], 7) ^ w[j-6];
        end
        for (int k = 0; k < 8; k++) r[k] = chain[k];
        for (int j = 0; j < 64; j++) begin
            tj = (j < 16) ? sm3_pkg::TCONST_LO : sm3_pkg::TCONST_HI;
            a12 = rl(r[0], 12);
            ss1 = rl(a12 + r[4] + rl(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                f = r[0] ^ r[1] ^ r[2];
                g = r[4] ^ r[5] ^ r[6];
            end else begin
                f = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                g = (r[4] & r[5]) | (~r[4] & r[6]);
            end
            t1 = f + r[3] + ss2 + (w[j] ^ w[j+4]);
            t2 = g + r[7] + ss1 + w[j];
            r[3] = r[2]; r[2] = rl(r[1], 9); r[1] = r[0]; r[0] = t1;
            r[7] = r[6]; r[6] = rl(r[5], 19); r[5] = r[4];
            r[4] = t2 ^ rl(t2, 9) ^ rl(t2, 17);
        end
        for (int k = 0; k < 8; k++) chain[k] ^= r[k];
    endfunction

    function void push(logic [31:0] x);
        blk[nwords] = x;
        nwords++;
        if (nwords == 16) begin
            compress();
            nwords = 0;
        end
    endfunction

    function void note_request(logic [31:0] data, logic [2:0] nb, logic fin);
        logic [31:0] mask;
        int n;
        if (!fin) begin
            bitlen += 32;
            push(data);
            return;
        end
        n = (nb > 4) ? 4 : nb;
        bitlen += 8 * n;
        if (n == 4) begin
            push(data);
            push({sm3_pkg::PAD_MARK, 24'h0});
        end else begin
            mask = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
            push((data & mask) | ({24'h0, sm3_pkg::PAD_MARK} << (24 - 8 * n)));
        end
        if (nwords > 14) push('0);
        while (nwords != 0 && nwords < 14) push('0);
        if (nwords == 0) for (int k = 0; k < 14; k++) push('0);
        push(bitlen[63:32]);
        push(bitlen[31:0]);
        for (int k = 0; k < 8; k++) begin
            exp_word.push_back(chain[k]);
            exp_index.push_back(k[2:0]);
            exp_last.push_back(k == 7);
        end
        restart();
    endfunction

    function void check_digest(logic [31:0] d, logic [2:0] idx, logic lw);
        if (exp_word.size() == 0) begin
            $error("digest word with no pending result: %h", d);
            errors++;
            return;
        end
        if (exp_word[0] !== d) begin
            $error("digest_word expected %h actual %h", exp_word[0], d);
            errors++;
        end
        if (exp_index[0] !== idx) begin
            $error("word_index expected %0d actual %0d", exp_index[0], idx);
            errors++;
        end
        if (exp_last[0] !== lw) begin
            $error("last_word expected %0d actual %0d", exp_last[0], lw);
            errors++;
        end
        void'(exp_word.pop_front());
        void'(exp_index.pop_front());
        void'(exp_last.pop_front());
    endfunction
endclass

module testbench;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [31:0] i_data_word = '0;
    logic [2:0]  i_valid_bytes = '0;
    logic        i_last = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    digest_board board = new();
    int burst_left = 0;
    int stall_mode = 0;

    sm3_hash_engine_unit dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_digest(o_digest_word, o_word_index, o_last_word);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic send_word(logic [31:0] data, logic [2:0] nb, logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data_word <= data;
        i_valid_bytes <= nb;
        i_last <= fin;
        do @(posedge i_clk); while (o_stall);
        board.note_request(data, nb, fin);
    endtask

    task automatic stop_input();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (board.exp_word.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_message(int nwords, logic [2:0] nb);
        for (int k = 0; k < nwords - 1; k++)
            send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
        send_word($urandom, nb, 1'b1);
    endtask

    initial begin
        int len;
        int sent;
        sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_word(32'h0, 3'd0, 1'b1);
        send_message(1, 3'd3);
        send_word(32'h61626300, 3'd3, 1'b1);
        send_word(32'hffffffff, 3'd4, 1'b1);
        send_message(14, 3'd4);
        send_message(14, 3'd1);
        send_message(15, 3'd2);
        send_message(16, 3'd4);
        send_message(16, 3'd7);
        send_message(3, 3'd5);
        stop_input();
        drain();
        repeat (100) @(posedge i_clk);
        while (sent < 70) begin
            stall_mode = $urandom_range(0, 2);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                              : $urandom_range(1, 16);
            send_message(len, 3'($urandom_range(0, 7)));
            sent += len;
            if ($urandom_range(0, 3) == 0) begin
                stop_input();
                drain();
            end
        end
        stop_input();
        stall_mode = 1;
        drain();
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.exp_word.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
